// ----- rtl/tre_pkg.sv -----
`timescale 1ns / 1ps

package tre_pkg;

  localparam int unsigned Letters = 26;

  typedef logic [4:0] letter_t;
  typedef letter_t wiring_t [Letters];

  // rotor positions of one stream
  typedef struct packed {
    letter_t slow;
    letter_t mid;
    letter_t fast;
  } pos_t;

  localparam logic [7:0] CharA = 8'h61;
  localparam logic [7:0] CharZ = 8'h7a;
  localparam logic [7:0] SepReset = 8'h20;

  // forward wirings of rotors I, II, III and reflector B
  localparam wiring_t RotorI = '{
    5'd4, 5'd10, 5'd12, 5'd5, 5'd11, 5'd6, 5'd3, 5'd16, 5'd21, 5'd25, 5'd13, 5'd19, 5'd14,
    5'd22, 5'd24, 5'd7, 5'd23, 5'd20, 5'd18, 5'd15, 5'd0, 5'd8, 5'd1, 5'd17, 5'd2, 5'd9};
  localparam wiring_t RotorII = '{
    5'd0, 5'd9, 5'd3, 5'd10, 5'd18, 5'd8, 5'd17, 5'd20, 5'd23, 5'd1, 5'd11, 5'd7, 5'd22,
    5'd19, 5'd12, 5'd2, 5'd16, 5'd6, 5'd25, 5'd13, 5'd15, 5'd24, 5'd5, 5'd21, 5'd14, 5'd4};
  localparam wiring_t RotorIII = '{
    5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd2, 5'd15, 5'd17, 5'd19, 5'd23, 5'd21, 5'd25,
    5'd13, 5'd24, 5'd4, 5'd8, 5'd22, 5'd6, 5'd0, 5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14};
  localparam wiring_t ReflB = '{
    5'd24, 5'd17, 5'd20, 5'd7, 5'd16, 5'd18, 5'd11, 5'd3, 5'd15, 5'd23, 5'd13, 5'd6, 5'd14,
    5'd10, 5'd12, 5'd8, 5'd4, 5'd1, 5'd5, 5'd25, 5'd2, 5'd22, 5'd21, 5'd9, 5'd0, 5'd19};

  // inverse wirings, for the return path
  localparam wiring_t InvI = '{
    5'd20, 5'd22, 5'd24, 5'd6, 5'd0, 5'd3, 5'd5, 5'd15, 5'd21, 5'd25, 5'd1, 5'd4, 5'd2,
    5'd10, 5'd12, 5'd19, 5'd7, 5'd23, 5'd18, 5'd11, 5'd17, 5'd8, 5'd13, 5'd16, 5'd14, 5'd9};
  localparam wiring_t InvII = '{
    5'd0, 5'd9, 5'd15, 5'd2, 5'd25, 5'd22, 5'd17, 5'd11, 5'd5, 5'd1, 5'd3, 5'd10, 5'd14,
    5'd19, 5'd24, 5'd20, 5'd16, 5'd6, 5'd4, 5'd13, 5'd7, 5'd23, 5'd12, 5'd8, 5'd21, 5'd18};
  localparam wiring_t InvIII = '{
    5'd19, 5'd0, 5'd6, 5'd1, 5'd15, 5'd2, 5'd18, 5'd3, 5'd16, 5'd4, 5'd20, 5'd5, 5'd21,
    5'd13, 5'd25, 5'd7, 5'd24, 5'd8, 5'd23, 5'd9, 5'd22, 5'd11, 5'd17, 5'd10, 5'd14, 5'd12};

  function automatic letter_t wire_lookup(input wiring_t tab, input letter_t idx);
    letter_t res;
    res = '0;
    if (idx < letter_t'(Letters)) begin
      res = tab[idx];
    end
    return res;
  endfunction

  // (a + b - c) mod 26, all operands already below 26
  function automatic letter_t mod_mix(input letter_t a, input letter_t b, input letter_t c);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 6'(Letters)) begin
      s = s - 6'(Letters);
    end
    if (s < {1'b0, c}) begin
      s = s + 6'(Letters);
    end
    s = s - {1'b0, c};
    return s[4:0];
  endfunction

endpackage

// ----- rtl/tre_scrambler.sv -----
`timescale 1ns / 1ps

module tre_scrambler import tre_pkg::*; (
  input  pos_t    pos_i,
  input  letter_t letter_i,
  output letter_t letter_o
);

  letter_t f1, f2, f3, rf, b3, b2, b1;

  // forward through I, II, III, then reflector
  assign f1 = wire_lookup(RotorI, mod_mix(letter_i, pos_i.fast, '0));
  assign f2 = wire_lookup(RotorII, mod_mix(f1, pos_i.mid, pos_i.fast));
  assign f3 = wire_lookup(RotorIII, mod_mix(f2, pos_i.slow, pos_i.mid));
  assign rf = wire_lookup(ReflB, mod_mix(f3, '0, pos_i.slow));

  // back through the inverse wirings
  assign b3 = wire_lookup(InvIII, mod_mix(rf, pos_i.slow, '0));
  assign b2 = wire_lookup(InvII, mod_mix(b3, pos_i.mid, pos_i.slow));
  assign b1 = wire_lookup(InvI, mod_mix(b2, pos_i.fast, pos_i.mid));

  assign letter_o = mod_mix(b1, '0, pos_i.fast);

endmodule

// ----- rtl/three_rotor_enigma_cipher_core.sv -----
`timescale 1ns / 1ps

// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+------------------------
// in       | input     | in_valid_i / in_stall_o    | req_type_i, char_in_i
// out      | output    | out_valid_o / out_stall_i  | char_out_o
// config   | input     | separator_we_i             | separator_wdata_i
//
// one item per cycle sustained while the output does not stall; each item
// passes two registers: the rotor step at the input register, the scrambler
// chain before the result register. reset clears both position sets to zero
// and the separator to space. a stalled output holds its item; the input stage
// keeps accepting as long as the result register can move on.

module three_rotor_enigma_cipher_core import tre_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       separator_we_i,
  input  logic [7:0] separator_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] char_out_o
);

  logic [7:0] sep_q;

  // position sets, index 0 encrypt, 1 decrypt
  pos_t pos_q [2];
  pos_t pos_cur, pos_step;

  // stage 1: stepped positions and letter index
  logic    s1_valid_q;
  logic    s1_pass_q;
  logic [7:0] s1_char_q;
  letter_t s1_letter_q;
  pos_t    s1_pos_q;

  // result register
  logic       out_valid_q;
  logic [7:0] out_char_q;

  logic in_acc, s1_adv, out_free, is_sep;
  letter_t in_letter, scr_letter;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign is_sep  = (char_in_i == sep_q);
  assign pos_cur = pos_q[req_type_i];

  // anything outside a to z counts as z
  assign in_letter = (char_in_i >= CharA && char_in_i <= CharZ) ?
                     letter_t'(char_in_i - CharA) : letter_t'(Letters - 1);

  // odometer step, no notches
  always_comb begin
    pos_step = pos_cur;
    if (pos_cur.fast == letter_t'(Letters - 1)) begin
      pos_step.fast = '0;
      if (pos_cur.mid == letter_t'(Letters - 1)) begin
        pos_step.mid  = '0;
        pos_step.slow = (pos_cur.slow == letter_t'(Letters - 1)) ? '0 : pos_cur.slow + 5'd1;
      end else begin
        pos_step.mid = pos_cur.mid + 5'd1;
      end
    end else begin
      pos_step.fast = pos_cur.fast + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q       <= SepReset;
      pos_q[0]    <= '0;
      pos_q[1]    <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (separator_we_i) begin
        sep_q <= separator_wdata_i;
      end
      // separator bytes leave the positions alone
      if (in_acc && !is_sep) begin
        pos_q[req_type_i] <= pos_step;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pass_q   <= is_sep;
      s1_char_q   <= char_in_i;
      s1_letter_q <= in_letter;
      s1_pos_q    <= pos_step;
    end
    if (s1_adv) begin
      out_char_q <= s1_pass_q ? s1_char_q : CharA + {3'b000, scr_letter};
    end
  end

  tre_scrambler u_scrambler (
    .pos_i    (s1_pos_q),
    .letter_i (s1_letter_q),
    .letter_o (scr_letter)
  );

  assign out_valid_o = out_valid_q;
  assign char_out_o  = out_char_q;

endmodule

// ----- test/enigma_stream_checker.sv -----
`timescale 1ns / 1ps

module enigma_stream_checker import tre_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       separator_we_i,
  input  logic [7:0] separator_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       req_type_i,
  input  logic [7:0] char_in_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] char_out_i,
  output int         errors_o,
  output int         pending_o
);

  typedef logic [8*26-1:0] wire_str_t;

  localparam wire_str_t WireI    = "ekmflgdqvzntowyhxuspaibrcj";
  localparam wire_str_t WireII   = "ajdksiruxblhwtmcqgznpyfvoe";
  localparam wire_str_t WireIII  = "bdfhjlcprtxvznyeiwgakmusqo";
  localparam wire_str_t ReflectB = "yruhqsldpxngokmiebfzcwvjat";

  logic [7:0] sep_char;
  pos_t       enc_pos;
  pos_t       dec_pos;
  logic [7:0] cipher_q[$];
  int         error_cnt;

  function automatic letter_t wire_at(input wire_str_t tab, input int idx);
    logic [7:0] c;
    c = tab[8*(25-idx) +: 8];
    return letter_t'(c - CharA);
  endfunction

  function automatic letter_t wire_back(input wire_str_t tab, input int v);
    letter_t res;
    res = '0;
    for (int i = 0; i < 26; i++) begin
      if (wire_at(tab, i) == letter_t'(v)) res = letter_t'(i);
    end
    return res;
  endfunction

  function automatic int mix26(input int a, input int b, input int c);
    return (a + b + 26 - c) % 26;
  endfunction

  // odometer step, no notches
  function automatic pos_t advance(input pos_t p);
    pos_t n;
    n = p;
    if (n.fast == 5'd25) begin
      n.fast = '0;
      if (n.mid == 5'd25) begin
        n.mid  = '0;
        n.slow = (n.slow == 5'd25) ? 5'd0 : n.slow + 5'd1;
      end else begin
        n.mid = n.mid + 5'd1;
      end
    end else begin
      n.fast = n.fast + 5'd1;
    end
    return n;
  endfunction

  function automatic letter_t scramble(input pos_t p, input letter_t x);
    letter_t v;
    v = wire_at(WireI, mix26(x, p.fast, 0));
    v = wire_at(WireII, mix26(v, p.mid, p.fast));
    v = wire_at(WireIII, mix26(v, p.slow, p.mid));
    v = wire_at(ReflectB, mix26(v, 0, p.slow));
    v = wire_back(WireIII, mix26(v, p.slow, 0));
    v = wire_back(WireII, mix26(v, p.mid, p.slow));
    v = wire_back(WireI, mix26(v, p.fast, p.mid));
    return letter_t'(mix26(v, 0, p.fast));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0] want;
    pos_t       p;
    letter_t    idx;
    if (!rst_ni) begin
      sep_char = SepReset;
      enc_pos  = '0;
      dec_pos  = '0;
      cipher_q.delete();
      error_cnt = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (separator_we_i) sep_char = separator_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        if (char_in_i == sep_char) begin
          want = char_in_i;
        end else begin
          p = advance(req_type_i ? dec_pos : enc_pos);
          if (req_type_i) dec_pos = p;
          else enc_pos = p;
          // anything outside a..z ciphers as z
          idx = (char_in_i >= CharA && char_in_i <= CharZ) ?
                letter_t'(char_in_i - CharA) : 5'd25;
          want = CharA + 8'(scramble(p, idx));
        end
        cipher_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (cipher_q.size() == 0) begin
          $error("char_out: expected none, actual %02h", char_out_i);
          error_cnt++;
        end else begin
          want = cipher_q.pop_front();
          if (char_out_i !== want) begin
            $error("char_out: expected %02h, actual %02h", want, char_out_i);
            error_cnt++;
          end
        end
      end
      errors_o  <= error_cnt;
      pending_o <= cipher_q.size();
    end
  end

endmodule

// ----- test/three_rotor_enigma_cipher_core_tb.sv -----
`timescale 1ns / 1ps

module three_rotor_enigma_cipher_core_tb import tre_pkg::*; ();

  localparam int NumPhases  = 7;
  localparam int PhaseItems = 150;
  localparam int HoldCycles = 150;
  localparam int CycleLimit = 300000;

  logic       clk_i;
  logic       rst_ni;
  logic       separator_we;
  logic [7:0] separator_wdata;
  logic       in_valid;
  logic       in_stall;
  logic       req_type;
  logic [7:0] char_in;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] char_out;

  int         fail_cnt;
  int         pending;
  int         cycle_cnt;

  // handshake-free flags between the sender and the receiver
  bit         quiet;     // no idling on either side
  bit         hold_req;  // sender asks for the long receiver hold-off
  bit         hold_done;

  logic [7:0] cur_sep;

  three_rotor_enigma_cipher_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .separator_we_i    (separator_we),
    .separator_wdata_i (separator_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .req_type_i        (req_type),
    .char_in_i         (char_in),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .char_out_o        (char_out)
  );

  // watches both channels and the separator port, predicts every result
  enigma_stream_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .separator_we_i    (separator_we),
    .separator_wdata_i (separator_wdata),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .req_type_i        (req_type),
    .char_in_i         (char_in),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .char_out_i        (char_out),
    .errors_o          (fail_cnt),
    .pending_o         (pending)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // watchdog
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int burst_left;
    int hold_left;
    bit stall_nxt;
    burst_left = 0;
    hold_left  = 0;
    out_stall  = 1'b0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_left = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_nxt = 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        stall_nxt = 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(1, 12) - 1;
        stall_nxt  = 1'b1;
      end else begin
        stall_nxt = 1'b0;
      end
      out_stall <= stall_nxt;
    end
  end

  // offer one item, starting from just after a rising edge; returns once accepted
  task automatic send_char(input logic rt, input logic [7:0] ch);
    int gap;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    char_in  <= ch;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // sender pauses until every expected result has come back
  task automatic drain_stream();
    @(negedge clk_i);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // separator changes only with the block idle
  task automatic set_separator(input logic [7:0] sep);
    drain_stream();
    @(negedge clk_i);
    separator_we    <= 1'b1;
    separator_wdata <= sep;
    @(negedge clk_i);
    separator_we    <= 1'b0;
    cur_sep = sep;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_char(input logic [7:0] sep);
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0:       c = sep;
      1, 2:    c = 8'($urandom_range(0, 255));
      default: c = CharA + 8'($urandom_range(0, 25));
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pick_separator();
    logic [7:0] s;
    case ($urandom_range(0, 2))
      0:       s = SepReset;
      1:       s = CharA + 8'($urandom_range(0, 25));
      default: s = 8'($urandom_range(0, 255));
    endcase
    return s;
  endfunction

  initial begin
    logic rt;
    rst_ni          = 1'b0;
    separator_we    = 1'b0;
    separator_wdata = 8'h00;
    in_valid        = 1'b0;
    req_type        = 1'b0;
    char_in         = 8'h00;
    quiet           = 1'b0;
    hold_req        = 1'b0;
    cur_sep         = SepReset;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, separator at its reset value: letters, both streams,
    // separator passthrough, bytes outside a..z
    send_char(1'b0, CharA);
    send_char(1'b0, CharA);
    send_char(1'b1, CharA);
    send_char(1'b0, CharZ);
    send_char(1'b1, SepReset);
    send_char(1'b0, SepReset);
    send_char(1'b0, 8'h00);
    send_char(1'b1, 8'hff);
    send_char(1'b0, CharA - 8'd1);
    send_char(1'b1, CharZ + 8'd1);
    send_char(1'b0, 8'h80);
    send_char(1'b1, CharA + 8'd12);

    // separator that is itself a letter: passes unchanged, no stepping
    set_separator(CharA + 8'd16);
    send_char(1'b0, CharA + 8'd16);
    send_char(1'b1, CharA + 8'd16);
    send_char(1'b0, SepReset);
    send_char(1'b0, CharA + 8'd15);

    // separator extremes
    set_separator(8'h00);
    send_char(1'b0, 8'h00);
    send_char(1'b1, 8'h00);
    send_char(1'b1, 8'hff);
    set_separator(8'hff);
    send_char(1'b0, 8'hff);
    send_char(1'b1, 8'hff);
    send_char(1'b0, 8'h00);

    // random phases; the encrypt stream gets most letters so its slow
    // rotor carries at least once
    for (int ph = 0; ph < NumPhases; ph++) begin
      set_separator(pick_separator());
      if (ph == 1) hold_req = 1'b1;
      if (ph == NumPhases - 1) quiet = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        rt = ($urandom_range(0, 4) == 0);
        send_char(rt, pick_char(cur_sep));
      end
    end

    drain_stream();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
